// ----- rtl/core/pbe_pkg.sv -----
`timescale 1ns / 1ps

package pbe_pkg;

  localparam int MAX_ROW_DEF   = 1024;
  localparam int OUT_LANES_DEF = 8;
  localparam int PIECE         = 128;   // longest literal or repeat piece
  localparam int ROW_W         = 11;    // row_bytes register width
  localparam int BYTE_W        = 8;
  localparam int MAX_LANES     = 8;     // byte lanes carried in tdata
  localparam int CNT_FIELD_W   = 4;     // byte_count field
  localparam int OUT_TDATA_W   = 72;    // 8 bytes + byte_count, padded to bytes
  localparam int CFG_AW        = 3;
  localparam int CFG_DW        = 32;

  // register index, taken from paddr[2]
  localparam logic REG_ROW_BYTES = 1'b0;

  // request from the sequencer to the packer
  typedef struct packed {
    logic              push;     // append one compressed byte
    logic [BYTE_W-1:0] data;
    logic              flush;    // close a partly filled pack as end of row
    logic              close;    // end of input transaction
    logic              row_end;  // transaction ended the row
  } pbe_op_t;

  typedef struct packed {
    logic ready;       // op taken this cycle
    logic pack_empty;  // no compressed bytes waiting in the pack
  } pbe_stat_t;

endpackage

// ----- rtl/core/packbits_row_encoder_top.sv -----
`timescale 1ns / 1ps
// PackBits row encoder.
// Input stream: one uncompressed row byte per transaction on in_tdata[7:0].
// Output stream: up to OUT_LANES compressed bytes per transaction;
//   out_tdata = {pad, byte_count, out_byte7 .. out_byte0}, tlast marks the
//   transaction holding the final byte of the row, tuser[0] marks the last
//   result produced by the current input byte.
// Config: APB register row_bytes at address 0 (0 acts as 1, clamped to
//   MAX_ROW); write it only while the encoder is idle.
// Flow: a byte that only extends a run or the lookahead passes the accept
//   and decide states. A byte that closes a run or a literal piece then sends
//   its compressed bytes one per cycle while the packer is ready, and the row
//   check and close states close the transaction; a row end adds tail checks,
//   lookahead moves and the final flush. A literal piece (up to 128 bytes) is
//   read back from the literal store one byte per cycle while the packer is
//   ready. A result is held until the next one or the end of the byte shows
//   whether it ends the burst; the last one moves out when the byte closes.
// Reset: rst_n is synchronous; it empties run, lookahead, literal count and
//   pack, and sets row_bytes to 1. The literal store needs no clearing.
// Stall: if out_tvalid waits and a result is also held, the sequencer pauses
//   and in_tready stays low until the current byte is fully handled.

module packbits_row_encoder_top import pbe_pkg::*; #(
  parameter int MAX_ROW   = MAX_ROW_DEF,
  parameter int OUT_LANES = OUT_LANES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [BYTE_W-1:0]      in_tdata,    // data_byte
  // output stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_byte0..out_byte7 [63:0], byte_count [67:64], zero pad [71:68]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,   // row_end
  output logic [0:0]             out_tuser,   // burst_end
  // APB register port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_AW-1:0]      paddr,
  input  logic [CFG_DW-1:0]      pwdata,
  output logic [CFG_DW-1:0]      prdata,
  output logic                   pready
);

  logic [ROW_W-1:0] row_bytes_r;
  logic             cfg_wr;
  pbe_op_t          op;
  pbe_stat_t        stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // word index is paddr[2]; only word 0 exists
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bytes_r <= ROW_W'(1);
    end else if (cfg_wr && paddr[2] == REG_ROW_BYTES) begin
      row_bytes_r <= pwdata[ROW_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_ROW_BYTES) ? CFG_DW'(row_bytes_r) : '0;

  // run / literal decisions, literal store, row bookkeeping
  pbe_seq #(
    .MAX_ROW (MAX_ROW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .row_bytes (row_bytes_r),
    .op        (op),
    .stat      (stat)
  );

  // byte packing, burst tagging and output register
  pbe_packer #(
    .OUT_LANES (OUT_LANES)
  ) u_packer (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- rtl/core/pbe_packer.sv -----
`timescale 1ns / 1ps

module pbe_packer import pbe_pkg::*; #(
  parameter int OUT_LANES = OUT_LANES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pbe_op_t                op,
  output pbe_stat_t              stat,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_byte0..out_byte7, byte_count, 4'b0 pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,   // row_end
  output logic [0:0]             out_tuser    // burst_end
);

  localparam int CNTW = $clog2(OUT_LANES + 1);

  logic [BYTE_W-1:0] lane_r     [OUT_LANES];
  logic [BYTE_W-1:0] lane_nxt   [OUT_LANES];
  logic [BYTE_W-1:0] res_lane   [OUT_LANES];
  logic [BYTE_W-1:0] hold_lane_r[OUT_LANES];
  logic [BYTE_W-1:0] out_lane_r [OUT_LANES];
  logic [CNTW-1:0]   cnt_r, cnt_nxt, cnt_inc, res_cnt;
  logic [CNTW-1:0]   hold_cnt_r, out_cnt_r;
  logic              hold_valid_r, hold_valid_nxt, hold_row_end_r;
  logic              out_valid_r, out_valid_nxt, out_last_r, out_burst_r;
  logic              out_free, ready, acc, full, new_res, move_out, move_burst;

  assign out_free = !out_valid_r || out_tready;
  assign ready    = !hold_valid_r || out_free;
  assign acc      = ready && (op.push || op.flush || op.close);
  assign cnt_inc  = cnt_r + CNTW'(1);
  assign full     = op.push && (cnt_inc == CNTW'(OUT_LANES));
  assign new_res  = acc && (full || op.flush);
  assign res_cnt  = op.push ? cnt_inc : cnt_r;

  assign move_out   = hold_valid_r && (new_res || (acc && op.close));
  assign move_burst = acc && op.close;

  assign stat.ready      = ready;
  assign stat.pack_empty = (cnt_r == '0);

  always_comb begin
    for (int i = 0; i < OUT_LANES; i++) begin
      res_lane[i] = (op.push && cnt_r == CNTW'(i)) ? op.data : lane_r[i];
      if (new_res) begin
        lane_nxt[i] = '0;
      end else if (acc) begin
        lane_nxt[i] = res_lane[i];
      end else begin
        lane_nxt[i] = lane_r[i];
      end
    end
    if (new_res) begin
      cnt_nxt = '0;
    end else if (acc && op.push) begin
      cnt_nxt = cnt_inc;
    end else begin
      cnt_nxt = cnt_r;
    end
    hold_valid_nxt = hold_valid_r;
    if (new_res) begin
      hold_valid_nxt = 1'b1;
    end else if (move_out) begin
      hold_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r && !out_tready;
    if (move_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < OUT_LANES; i++) begin
        lane_r[i] <= '0;
      end
      cnt_r        <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      lane_r       <= lane_nxt;
      cnt_r        <= cnt_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (move_out) begin
      out_lane_r  <= hold_lane_r;
      out_cnt_r   <= hold_cnt_r;
      out_burst_r <= move_burst;
      out_last_r  <= hold_row_end_r || (move_burst && op.row_end);
    end
    if (new_res) begin
      hold_lane_r    <= res_lane;
      hold_cnt_r     <= res_cnt;
      hold_row_end_r <= op.flush;
    end
  end

  for (genvar g = 0; g < MAX_LANES; g++) begin : g_lane
    if (g < OUT_LANES) begin : g_used
      assign out_tdata[BYTE_W*g +: BYTE_W] = out_lane_r[g];
    end else begin : g_zero
      assign out_tdata[BYTE_W*g +: BYTE_W] = '0;
    end
  end

  assign out_tdata[BYTE_W*MAX_LANES +: CNT_FIELD_W] = CNT_FIELD_W'(out_cnt_r);
  assign out_tdata[OUT_TDATA_W-1:BYTE_W*MAX_LANES+CNT_FIELD_W] = '0;
  assign out_tvalid   = out_valid_r;
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_burst_r;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !move_out)
    else $error("result register overwritten while stalled");
  a_pack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != CNTW'(OUT_LANES))
    else $error("full pack not handed on");
  a_close_drains: assert property (@(posedge clk) disable iff (!rst_n)
    acc && op.close |=> !hold_valid_r)
    else $error("held result left behind at end of transaction");
`endif

endmodule

// ----- rtl/core/pbe_seq.sv -----
`timescale 1ns / 1ps

module pbe_seq import pbe_pkg::*; #(
  parameter int MAX_ROW = MAX_ROW_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic [ROW_W-1:0]  row_bytes,
  output pbe_op_t           op,
  input  pbe_stat_t         stat
);

  localparam int CW   = $clog2(MAX_ROW + 1);
  localparam int CMPW = (CW > ROW_W) ? CW : ROW_W;
  localparam int PW   = $clog2(PIECE);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECIDE   = 4'd1;
  localparam logic [3:0] S_RUN_HDR  = 4'd2;
  localparam logic [3:0] S_RUN_VAL  = 4'd3;
  localparam logic [3:0] S_LIT_HDR  = 4'd4;
  localparam logic [3:0] S_LIT_DATA = 4'd5;
  localparam logic [3:0] S_ROWCHK   = 4'd6;
  localparam logic [3:0] S_TAIL_RUN = 4'd7;
  localparam logic [3:0] S_TAIL_ADD = 4'd8;
  localparam logic [3:0] S_TAIL_LIT = 4'd9;
  localparam logic [3:0] S_FINAL    = 4'd10;
  localparam logic [3:0] S_CLOSE    = 4'd11;

  logic [3:0]        state_r, state_nxt, ret_r, ret_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic [PW:0]       lit_cnt_r, lit_cnt_nxt, lit_idx_r, lit_idx_nxt;
  logic [15:0]       la_r, la_nxt;
  logic [1:0]        la_cnt_r, la_cnt_nxt;
  logic [BYTE_W-1:0] run_val_r, run_val_nxt;
  logic [PW:0]       run_len_r, run_len_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic              row_end_r, row_end_nxt, keep_r, keep_nxt;

  logic [BYTE_W-1:0] lit_mem [PIECE];
  logic [BYTE_W-1:0] lit_q_r;
  logic              mem_we;

  logic [CMPW-1:0]   lim, rb_ext, col_inc;
  logic              row_done;

  assign in_tready = (state_r == S_IDLE);

  // effective row length: 0 acts as 1, clamp at MAX_ROW
  assign rb_ext   = CMPW'(row_bytes);
  assign lim      = (row_bytes == '0) ? CMPW'(1) :
                    (rb_ext > CMPW'(MAX_ROW)) ? CMPW'(MAX_ROW) : rb_ext;
  assign col_inc  = CMPW'(col_r) + CMPW'(1);
  assign row_done = (col_inc >= lim);

  // Literal store: written only in add cycles, whose read data is unused,
  // so no same-entry forwarding is needed.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      lit_mem[lit_cnt_r[PW-1:0]] <= la_r[BYTE_W-1:0];
    end
    lit_q_r <= lit_mem[lit_idx_nxt[PW-1:0]];
  end

  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    byte_nxt    = byte_r;
    lit_cnt_nxt = lit_cnt_r;
    lit_idx_nxt = lit_idx_r;
    la_nxt      = la_r;
    la_cnt_nxt  = la_cnt_r;
    run_val_nxt = run_val_r;
    run_len_nxt = run_len_r;
    col_nxt     = col_r;
    row_end_nxt = row_end_r;
    keep_nxt    = keep_r;
    mem_we      = 1'b0;
    op          = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          byte_nxt  = in_byte;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        row_end_nxt = row_done;
        col_nxt     = row_done ? '0 : CW'(col_inc);
        ret_nxt     = S_ROWCHK;
        state_nxt   = row_done ? S_TAIL_RUN : S_IDLE;
        if (run_len_r != '0) begin
          if (byte_r == run_val_r) begin
            if (run_len_r >= (PW+1)'(PIECE)) begin
              // full piece goes out, run carries on at length 1
              keep_nxt  = 1'b1;
              state_nxt = S_RUN_HDR;
            end else begin
              run_len_nxt = run_len_r + 1'b1;
            end
          end else begin
            keep_nxt   = 1'b0;
            la_nxt     = {8'h00, byte_r};
            la_cnt_nxt = 2'd1;
            state_nxt  = S_RUN_HDR;
          end
        end else if (la_cnt_r == 2'd2) begin
          if (la_r[7:0] == byte_r && la_r[15:8] == byte_r) begin
            run_val_nxt = byte_r;
            run_len_nxt = (PW+1)'(3);
            la_nxt      = '0;
            la_cnt_nxt  = 2'd0;
            if (lit_cnt_r != '0) begin
              state_nxt = S_LIT_HDR;
            end
          end else begin
            mem_we      = 1'b1;
            lit_cnt_nxt = lit_cnt_r + 1'b1;
            la_nxt      = {byte_r, la_r[15:8]};
            if (lit_cnt_r == (PW+1)'(PIECE - 1)) begin
              state_nxt = S_LIT_HDR;
            end
          end
        end else begin
          la_nxt     = (la_cnt_r == 2'd0) ? {8'h00, byte_r} : {byte_r, la_r[7:0]};
          la_cnt_nxt = la_cnt_r + 2'd1;
        end
      end
      S_RUN_HDR: begin
        op.push = 1'b1;
        op.data = 8'd1 - BYTE_W'(run_len_r);
        if (stat.ready) begin
          state_nxt = S_RUN_VAL;
        end
      end
      S_RUN_VAL: begin
        op.push = 1'b1;
        op.data = run_val_r;
        if (stat.ready) begin
          run_len_nxt = keep_r ? (PW+1)'(1) : '0;
          state_nxt   = ret_r;
        end
      end
      S_LIT_HDR: begin
        op.push     = 1'b1;
        op.data     = BYTE_W'(lit_cnt_r - 1'b1);
        lit_idx_nxt = '0;
        if (stat.ready) begin
          state_nxt = S_LIT_DATA;
        end
      end
      S_LIT_DATA: begin
        op.push = 1'b1;
        op.data = lit_q_r;
        if (stat.ready) begin
          if (lit_idx_r + 1'b1 == lit_cnt_r) begin
            lit_cnt_nxt = '0;
            state_nxt   = ret_r;
          end else begin
            lit_idx_nxt = lit_idx_r + 1'b1;
          end
        end
      end
      S_ROWCHK: begin
        state_nxt = row_end_r ? S_TAIL_RUN : S_CLOSE;
      end
      S_TAIL_RUN: begin
        if (run_len_r != '0) begin
          keep_nxt  = 1'b0;
          ret_nxt   = S_TAIL_ADD;
          state_nxt = S_RUN_HDR;
        end else begin
          state_nxt = S_TAIL_ADD;
        end
      end
      S_TAIL_ADD: begin
        // leftover lookahead bytes join the literal, oldest first
        if (la_cnt_r != 2'd0) begin
          mem_we      = 1'b1;
          lit_cnt_nxt = lit_cnt_r + 1'b1;
          la_nxt      = {8'h00, la_r[15:8]};
          la_cnt_nxt  = la_cnt_r - 2'd1;
          if (lit_cnt_r == (PW+1)'(PIECE - 1)) begin
            ret_nxt   = S_TAIL_ADD;
            state_nxt = S_LIT_HDR;
          end
        end else begin
          state_nxt = S_TAIL_LIT;
        end
      end
      S_TAIL_LIT: begin
        if (lit_cnt_r != '0) begin
          ret_nxt   = S_FINAL;
          state_nxt = S_LIT_HDR;
        end else begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        if (!stat.pack_empty) begin
          op.flush = 1'b1;
          if (stat.ready) begin
            state_nxt = S_CLOSE;
          end
        end else begin
          state_nxt = S_CLOSE;
        end
      end
      S_CLOSE: begin
        op.close   = 1'b1;
        op.row_end = row_end_r;
        if (stat.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ret_r     <= S_ROWCHK;
      lit_cnt_r <= '0;
      lit_idx_r <= '0;
      la_r      <= '0;
      la_cnt_r  <= '0;
      run_val_r <= '0;
      run_len_r <= '0;
      col_r     <= '0;
      row_end_r <= 1'b0;
      keep_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ret_r     <= ret_nxt;
      lit_cnt_r <= lit_cnt_nxt;
      lit_idx_r <= lit_idx_nxt;
      la_r      <= la_nxt;
      la_cnt_r  <= la_cnt_nxt;
      run_val_r <= run_val_nxt;
      run_len_r <= run_len_nxt;
      col_r     <= col_nxt;
      row_end_r <= row_end_nxt;
      keep_r    <= keep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

`ifndef SYNTHESIS
  // a run closed by a new byte still holds its length while its header goes out
  a_run_no_lookahead: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE && run_len_r != '0 |-> la_cnt_r == 2'd0)
    else $error("lookahead bytes held during a run");
  a_lit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lit_cnt_r <= (PW+1)'(PIECE))
    else $error("literal store overflow");
  a_lit_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LIT_DATA |-> lit_idx_r < lit_cnt_r)
    else $error("literal read beyond stored bytes");
`endif

endmodule
